[src/fcis_pkg.sv]
// fcis_pkg: shared types and codes for the fixed-capacity integer set.
// Request kinds, sequencer states and the value and count widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcis_pkg;

    // Request kinds carried on the kind field
    typedef enum logic [1:0] {
        KIND_QUERY  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_ACT  = 6'b000100,
        S_MOVE = 6'b001000,
        S_RESP = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

endpackage

`default_nettype wire

[src/fcis_ram.sv]
// fcis_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fcis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/fixed_capacity_integer_set.sv]
// fixed_capacity_integer_set: unordered set of distinct 32-bit values with a
// sequencer that scans the entry RAM through one shared equality comparator.
// Depends on fcis_pkg and fcis_ram.
//
// Usage
// - Request channel in_valid/in_ready carries kind (query, insert, remove,
//   clear) and value. Result channel out_valid/out_ready carries ok and the
//   element count after the request.
// - One request at a time. A request walks the stored entries one per cycle
//   through the single comparator, reading the entry RAM at one address a
//   cycle, and stops at the first match or at the fill count.
// - Clear goes from the request beat straight to the response step; query,
//   insert and remove first scan the stored entries (none when the set is
//   empty, at most CAPACITY), then act, and a successful remove adds a move
//   step before the response. in_ready rises at the same edge that loads
//   the result into the output register.
// - The output register holds a finished result while the receiver stalls;
//   the sequencer waits in its response step until that register is free.
// - Reset empties the set and clears the handshakes. The entry RAM is not
//   cleared: slots at or above the count are never used.
// - count is the fill count masked to 5 bits.
`timescale 1ns / 1ps
`default_nettype none

module fixed_capacity_integer_set #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [4:0]  count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    fcis_pkg::state_t state_reg, state_next;
    fcis_pkg::kind_t  kind_reg, kind_next;
    logic [fcis_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic          found_reg, found_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          res_ok_reg, res_ok_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_ok_reg, out_ok_next;
    logic [fcis_pkg::COUNT_W-1:0] out_count_reg, out_count_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [fcis_pkg::VALUE_W-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [fcis_pkg::VALUE_W-1:0] ram_rdata;

    logic          hit;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] fill_dec;
    logic [CW+fcis_pkg::COUNT_W-1:0] fill_wide;
    logic          out_free;

    fcis_ram #(
        .WIDTH (fcis_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared comparator and index arithmetic
    assign hit       = (ram_rdata == value_reg);
    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign fill_dec  = fill_reg - CW'(1);
    assign fill_wide = {{fcis_pkg::COUNT_W{1'b0}}, fill_reg};
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == fcis_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign count     = out_count_reg;

    // count after an insert
    function automatic logic [CW-1:0] idx_inc_fill(input logic [CW-1:0] f);
        idx_inc_fill = f + CW'(1);
    endfunction

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        fill_next      = fill_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_count_next = out_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = value_reg;
        ram_raddr      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fcis_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = fcis_pkg::kind_t'(kind);
                    value_next = value;
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (fcis_pkg::kind_t'(kind) == fcis_pkg::KIND_CLEAR)
                    begin
                        fill_next   = '0;
                        res_ok_next = 1'b1;
                        state_next  = fcis_pkg::S_RESP;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = fcis_pkg::S_ACT;
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        state_next = fcis_pkg::S_SCAN;
                    end
                end
            end

            // one entry per cycle; read of the next slot overlaps the compare
            fcis_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                    state_next = fcis_pkg::S_ACT;
                end
                else if (idx_inc < fill_reg)
                begin
                    idx_next   = idx_inc[IW-1:0];
                    ram_raddr  = idx_inc[IW-1:0];
                end
                else
                begin
                    state_next = fcis_pkg::S_ACT;
                end
            end

            fcis_pkg::S_ACT:
            begin
                state_next = fcis_pkg::S_RESP;
                case (kind_reg)
                    fcis_pkg::KIND_QUERY:
                    begin
                        res_ok_next = found_reg;
                    end
                    fcis_pkg::KIND_INSERT:
                    begin
                        if (!found_reg && (fill_reg < CW'(CAPACITY)))
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = fill_reg[IW-1:0];
                            ram_wdata   = value_reg;
                            fill_next   = idx_inc_fill(fill_reg);
                            res_ok_next = 1'b1;
                        end
                        else
                        begin
                            res_ok_next = 1'b0;
                        end
                    end
                    fcis_pkg::KIND_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            // fetch the last entry to fill the hole
                            ram_raddr  = fill_dec[IW-1:0];
                            state_next = fcis_pkg::S_MOVE;
                        end
                        else
                        begin
                            res_ok_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        res_ok_next = 1'b1;
                    end
                endcase
            end

            fcis_pkg::S_MOVE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = slot_reg;
                ram_wdata   = ram_rdata;
                fill_next   = fill_dec;
                res_ok_next = 1'b1;
                state_next  = fcis_pkg::S_RESP;
            end

            fcis_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_count_next = fill_wide[fcis_pkg::COUNT_W-1:0];
                    state_next     = fcis_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fcis_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcis_pkg::S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        idx_reg       <= idx_next;
        slot_reg      <= slot_next;
        found_reg     <= found_next;
        res_ok_reg    <= res_ok_next;
        out_ok_reg    <= out_ok_next;
        out_count_reg <= out_count_next;
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == fcis_pkg::KIND_CLEAR)) |=> (fill_reg == '0))
        else $error("clear did not empty the set");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == fcis_pkg::S_ACT) || (state_reg == fcis_pkg::S_MOVE)))
        else $error("entry write outside insert or move step");

    a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcis_pkg::S_MOVE) |=> (fill_reg == $past(fill_dec)))
        else $error("remove did not shrink the count by one");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fcis_pkg::S_RESP))
        else $error("result loaded outside response step");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// tb_top: self-checking testbench for fixed_capacity_integer_set.
// A set model in a small scoreboard class predicts ok and count for each
// request beat. A task drives requests, a process out_ready. Depends on fcis_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY   = 16;
    localparam int MAX_SHOWN  = 10;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = CAPACITY + 14;
    localparam int POOL_MAX   = 32;

    // One predicted result beat
    typedef struct packed {
        logic       ok;
        logic [4:0] count;
    } set_result_t;

    // Set model plus the queue of results still to arrive
    class set_scoreboard;
        logic [31:0]  slots [CAPACITY];
        logic [4:0]   fill;
        set_result_t  awaited [$];
        int           errors;

        function new();
            fill   = '0;
            errors = 0;
        endfunction

        // Slot holding v, or fill when v is absent
        function int locate(logic [31:0] v);
            for (int i = 0; i < fill; i++)
            begin
                if (slots[i] == v)
                    return i;
            end
            return fill;
        endfunction

        function void note_request(fcis_pkg::kind_t k, logic [31:0] v);
            set_result_t r;
            int          idx;
            r.ok = 1'b0;
            case (k)
                fcis_pkg::KIND_QUERY:
                begin
                    r.ok = (locate(v) < fill);
                end
                fcis_pkg::KIND_INSERT:
                begin
                    if (locate(v) >= fill && fill < CAPACITY)
                    begin
                        slots[fill] = v;
                        fill = fill + 5'd1;
                        r.ok = 1'b1;
                    end
                end
                fcis_pkg::KIND_REMOVE:
                begin
                    idx = locate(v);
                    if (fill > 0 && idx < fill)
                    begin
                        // last entry moves into the freed slot
                        slots[idx] = slots[fill - 1];
                        fill = fill - 5'd1;
                        r.ok = 1'b1;
                    end
                end
                default:
                begin
                    fill = '0;
                    r.ok = 1'b1;
                end
            endcase
            r.count = fill;
            awaited.push_back(r);
        endfunction

        function void check_result(logic got_ok, logic [4:0] got_count);
            set_result_t e;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result beat: ok=%0b count=%0d", got_ok, got_count);
                return;
            end
            e = awaited.pop_front();
            if (got_ok !== e.ok || got_count !== e.count)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("mismatch: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                             e.ok, e.count, got_ok, got_count);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic        ok;
    logic [4:0]  count;

    set_scoreboard sb;
    bit            calm;
    bit            hold_go;
    bit            hold_done;
    int            cycles;
    logic [31:0]   value_pool [POOL_MAX];

    fixed_capacity_integer_set #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .count     (count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Known values from time zero
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = fcis_pkg::KIND_QUERY;
        value     = '0;
        calm      = 1'b0;
        hold_go   = 1'b0;
        hold_done = 1'b0;
        sb        = new();
    end

    // Beat monitor: note requests, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(fcis_pkg::kind_t'(kind), value);
            if (out_valid && out_ready)
                sb.check_result(ok, count);
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                for (int n = 0; n < HOLD_LEN; n++)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 11);
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Offer one request beat; returns at the edge where it is taken
    task automatic send_request(input fcis_pkg::kind_t k, input logic [31:0] v);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Fresh value pool: extremes, random words and single-bit neighbours
    task automatic refill_pool();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        for (int i = 2; i < POOL_MAX; i++)
        begin
            if (i % 3 == 0)
                value_pool[i] = value_pool[i - 1] ^ (32'h1 << $urandom_range(0, 31));
            else
                value_pool[i] = $urandom;
        end
    endtask

    // Random requests drawn mostly from a small pool so that hits happen
    task automatic run_phase(input int n, input int pool_n, input int clear_pct);
        int              r;
        fcis_pkg::kind_t k;
        logic [31:0]     v;
        refill_pool();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < clear_pct)
                k = fcis_pkg::KIND_CLEAR;
            else if (r < clear_pct + 45)
                k = fcis_pkg::KIND_INSERT;
            else if (r < clear_pct + 70)
                k = fcis_pkg::KIND_QUERY;
            else
                k = fcis_pkg::KIND_REMOVE;
            if ($urandom_range(0, 9) == 0)
                v = $urandom;
            else
                v = value_pool[$urandom_range(0, pool_n - 1)];
            send_request(k, v);
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty set, extremes, duplicates, both remove paths, clear
        send_request(fcis_pkg::KIND_QUERY,  32'h0000_0000);
        send_request(fcis_pkg::KIND_REMOVE, 32'h0000_0000);
        send_request(fcis_pkg::KIND_INSERT, 32'h8000_0000);
        send_request(fcis_pkg::KIND_INSERT, 32'h7FFF_FFFF);
        send_request(fcis_pkg::KIND_INSERT, 32'h0000_0000);
        send_request(fcis_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        send_request(fcis_pkg::KIND_QUERY,  32'h7FFF_FFFF);
        send_request(fcis_pkg::KIND_INSERT, 32'h8000_0000);
        send_request(fcis_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
        send_request(fcis_pkg::KIND_REMOVE, 32'h8000_0000);
        send_request(fcis_pkg::KIND_QUERY,  32'h8000_0000);
        send_request(fcis_pkg::KIND_QUERY,  32'h0000_0000);
        send_request(fcis_pkg::KIND_REMOVE, 32'h0000_0001);
        send_request(fcis_pkg::KIND_CLEAR,  32'hFFFF_FFFF);
        send_request(fcis_pkg::KIND_QUERY,  32'h0000_0000);
        send_request(fcis_pkg::KIND_REMOVE, 32'h7FFF_FFFF);
        send_request(fcis_pkg::KIND_CLEAR,  32'h0000_0000);
        send_request(fcis_pkg::KIND_INSERT, 32'h7FFF_FFFF);

        // Random phases
        run_phase(200, 4, 3);
        run_phase(200, 20, 1);
        calm = 1'b1;
        run_phase(200, 24, 0);
        calm = 1'b0;
        hold_go = 1'b1;
        run_phase(200, 12, 2);
        run_phase(200, 32, 1);
        run_phase(200, 8, 5);
        run_phase(200, 18, 1);
        in_valid <= 1'b0;

        // Drain, then allow for stray beats
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[fixed_capacity_integer_set.f]
src/fcis_pkg.sv
src/fcis_ram.sv
src/fixed_capacity_integer_set.sv
verif/tb_top.sv
